>>> hdl/owtr_pkg.sv
// Shared types and constants for the one-wire temperature reader.
`default_nettype none
package owtr_pkg;

  localparam int unsigned NumCfg  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned TickW   = 20;

  typedef enum logic [2:0] {
    CFG_RESET_LOW  = 3'd0,
    CFG_PRES_WIN   = 3'd1,
    CFG_SLOT       = 3'd2,
    CFG_WRITE_LOW  = 3'd3,
    CFG_READ_SAMP  = 3'd4,
    CFG_CONV_WAIT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_RST   = 4'd1,
    PH_PRES  = 4'd2,
    PH_WRITE = 4'd3,
    PH_CONV  = 4'd4,
    PH_READ  = 4'd5
  } phase_t;

  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadSp  = 8'hBE;

  localparam logic [9:0]  RstResetLow  = 10'd480;
  localparam logic [12:0] RstPresWin   = 13'd480;
  localparam logic [7:0]  RstSlot      = 8'd70;
  localparam logic [3:0]  RstWriteLow  = 4'd2;
  localparam logic [5:0]  RstReadSamp  = 6'd12;
  localparam logic [19:0] RstConvWait  = 20'd750000;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [12:0] presence_window_ticks;
    logic [7:0]  slot_ticks;
    logic [3:0]  write_low_ticks;
    logic [5:0]  read_sample_tick;
    logic [19:0] conv_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        no_device;
    logic [15:0] temperature;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/owtr_seq.sv
// Bus sequencer: state registers and the per-tick step logic.
`default_nettype none
module owtr_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            start_req,
  input  wire logic            line_in,
  input  wire owtr_pkg::cfg_t  cfg,
  output owtr_pkg::res_t       res
);

  owtr_pkg::phase_t                 phase_r, phase_nxt;
  logic [owtr_pkg::TickW-1:0]       tick_r, tick_nxt;
  logic [2:0]                       bit_r, bit_nxt;
  logic [2:0]                       byte_r, byte_nxt;
  logic [7:0]                       shift_r, shift_nxt;
  logic [15:0]                      temp_r, temp_nxt;
  logic                             missed_r, missed_nxt;
  logic                             seen_r, seen_nxt;

  logic [owtr_pkg::TickW:0]         tick_inc;
  logic [owtr_pkg::TickW-1:0]       slot_len;
  logic [owtr_pkg::TickW-1:0]       len_rst;
  logic [owtr_pkg::TickW-1:0]       len_pres;
  logic [owtr_pkg::TickW-1:0]       len_conv;
  logic                             slot_end;
  logic                             drive;
  logic                             done;
  logic                             byte_last;

  always_comb begin
    slot_len = (cfg.slot_ticks == 8'd0) ? 20'd1 : {12'd0, cfg.slot_ticks};
    len_rst  = (cfg.reset_low_ticks == 10'd0) ? 20'd1 : {10'd0, cfg.reset_low_ticks};
    len_pres = (cfg.presence_window_ticks == 13'd0) ? 20'd1
                                                     : {7'd0, cfg.presence_window_ticks};
    len_conv = (cfg.conv_wait_ticks == 20'd0) ? 20'd1 : cfg.conv_wait_ticks;

    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    byte_nxt   = byte_r;
    shift_nxt  = shift_r;
    temp_nxt   = temp_r;
    missed_nxt = missed_r;
    seen_nxt   = seen_r;
    drive      = 1'b0;
    done       = 1'b0;
    slot_end   = 1'b0;
    byte_last  = 1'b0;

    if (phase_nxt != owtr_pkg::PH_RST && phase_nxt != owtr_pkg::PH_PRES &&
        phase_nxt != owtr_pkg::PH_WRITE && phase_nxt != owtr_pkg::PH_CONV &&
        phase_nxt != owtr_pkg::PH_READ) begin
      phase_nxt = owtr_pkg::PH_IDLE;
    end
    if (phase_nxt == owtr_pkg::PH_IDLE && start_req) begin
      phase_nxt  = owtr_pkg::PH_RST;
      tick_nxt   = '0;
      bit_nxt    = '0;
      byte_nxt   = '0;
      missed_nxt = 1'b0;
      seen_nxt   = 1'b0;
    end
    tick_inc = {1'b0, tick_nxt} + 21'd1;

    case (phase_nxt)
      owtr_pkg::PH_RST: begin
        drive = 1'b1;
        if (tick_inc >= {1'b0, len_rst}) begin
          phase_nxt = owtr_pkg::PH_PRES;
          tick_nxt  = '0;
          seen_nxt  = 1'b0;
        end else begin
          tick_nxt = tick_inc[owtr_pkg::TickW-1:0];
        end
      end
      owtr_pkg::PH_PRES: begin
        if (!line_in) begin
          seen_nxt = 1'b1;
        end
        if (tick_inc >= {1'b0, len_pres}) begin
          if (!seen_nxt) begin
            missed_nxt = 1'b1;
          end
          shift_nxt = owtr_pkg::CmdSkipRom;
          bit_nxt   = '0;
          tick_nxt  = '0;
          phase_nxt = owtr_pkg::PH_WRITE;
        end else begin
          tick_nxt = tick_inc[owtr_pkg::TickW-1:0];
        end
      end
      owtr_pkg::PH_WRITE: begin
        slot_end = tick_inc >= {1'b0, slot_len};
        drive = (tick_nxt < {16'd0, cfg.write_low_ticks}) || (!shift_nxt[0] && !slot_end);
        if (slot_end) begin
          shift_nxt = {1'b0, shift_nxt[7:1]};
          if (bit_nxt == 3'd7) begin
            byte_last = 1'b1;
          end else begin
            bit_nxt  = bit_nxt + 3'd1;
            tick_nxt = '0;
          end
        end else begin
          tick_nxt = tick_inc[owtr_pkg::TickW-1:0];
        end
      end
      owtr_pkg::PH_CONV: begin
        if (tick_inc >= {1'b0, len_conv}) begin
          phase_nxt = owtr_pkg::PH_RST;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc[owtr_pkg::TickW-1:0];
        end
      end
      owtr_pkg::PH_READ: begin
        slot_end = tick_inc >= {1'b0, slot_len};
        drive = tick_nxt < {16'd0, cfg.write_low_ticks};
        if (tick_nxt == {14'd0, cfg.read_sample_tick} ||
            (slot_end && tick_nxt < {14'd0, cfg.read_sample_tick})) begin
          shift_nxt = {line_in, shift_nxt[7:1]};
        end
        if (slot_end) begin
          if (bit_nxt == 3'd7) begin
            byte_last = 1'b1;
          end else begin
            bit_nxt  = bit_nxt + 3'd1;
            tick_nxt = '0;
          end
        end else begin
          tick_nxt = tick_inc[owtr_pkg::TickW-1:0];
        end
      end
      default: begin
      end
    endcase

    if (byte_last) begin
      byte_nxt = byte_r + 3'd1;
      tick_nxt = '0;
      bit_nxt  = '0;
      case (byte_r)
        3'd0: begin
          shift_nxt = owtr_pkg::CmdConvert;
          phase_nxt = owtr_pkg::PH_WRITE;
        end
        3'd1: phase_nxt = owtr_pkg::PH_CONV;
        3'd2: begin
          shift_nxt = owtr_pkg::CmdReadSp;
          phase_nxt = owtr_pkg::PH_WRITE;
        end
        3'd3: begin
          shift_nxt = '0;
          phase_nxt = owtr_pkg::PH_READ;
        end
        3'd4: begin
          temp_nxt  = {8'd0, shift_nxt};
          shift_nxt = '0;
          phase_nxt = owtr_pkg::PH_READ;
        end
        3'd5: begin
          temp_nxt  = {shift_nxt, temp_r[7:0]};
          phase_nxt = owtr_pkg::PH_IDLE;
          done      = 1'b1;
        end
        default: phase_nxt = owtr_pkg::PH_IDLE;
      endcase
    end

    res.drive_low   = drive;
    res.busy_res    = (phase_r != owtr_pkg::PH_IDLE && phase_r != owtr_pkg::PH_RST &&
                       phase_r != owtr_pkg::PH_PRES && phase_r != owtr_pkg::PH_WRITE &&
                       phase_r != owtr_pkg::PH_CONV && phase_r != owtr_pkg::PH_READ)
                      ? start_req : (phase_r != owtr_pkg::PH_IDLE || start_req);
    res.done_res    = done;
    res.no_device   = missed_nxt;
    res.temperature = done ? temp_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= owtr_pkg::PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      byte_r   <= '0;
      shift_r  <= '0;
      temp_r   <= '0;
      missed_r <= 1'b0;
      seen_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      byte_r   <= byte_nxt;
      shift_r  <= shift_nxt;
      temp_r   <= temp_nxt;
      missed_r <= missed_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/one_wire_temperature_reader.sv
// Top level: one-wire temperature reader with config registers and result register.
// Each input request is one bus tick carrying start_req and the sampled line
// level line_in. Every accepted request yields exactly one result: the bus drive
// for that tick (drive_low), busy_res, done_res, no_device and temperature, the
// last nonzero only on the tick the second read byte completes.
// A request is accepted when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// The result of a request is registered: it sits in the output register on the
// cycle after it is accepted. Throughput is one request per cycle while in_stall
// is low, as the sequencer steps once per accepted request; in_stall rises only
// while a result waits in the output register and the receiver stalls it.
// Registers are written through the cfg_ channel (index 0..5 in the order reset
// low, presence window, slot, write low, read sample, conversion wait); cfg_ready
// is always high and indexes past the list are dropped.
// Synchronous reset returns the sequencer to idle, clears the output valid flag and
// loads the default timings.
`default_nettype none
module one_wire_temperature_reader (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_start_req,
  input  wire logic                          in_line_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_drive_low,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_no_device,
  output logic [15:0]                        out_temperature,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [owtr_pkg::CfgDataW-1:0] cfg_data
);

  owtr_pkg::cfg_t cfg_r;
  owtr_pkg::res_t res;
  owtr_pkg::res_t res_r;
  logic           out_valid_r, out_valid_nxt;
  logic           in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks       <= owtr_pkg::RstResetLow;
      cfg_r.presence_window_ticks <= owtr_pkg::RstPresWin;
      cfg_r.slot_ticks            <= owtr_pkg::RstSlot;
      cfg_r.write_low_ticks       <= owtr_pkg::RstWriteLow;
      cfg_r.read_sample_tick      <= owtr_pkg::RstReadSamp;
      cfg_r.conv_wait_ticks       <= owtr_pkg::RstConvWait;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        owtr_pkg::CFG_RESET_LOW: cfg_r.reset_low_ticks       <= cfg_data[9:0];
        owtr_pkg::CFG_PRES_WIN:  cfg_r.presence_window_ticks <= cfg_data[12:0];
        owtr_pkg::CFG_SLOT:      cfg_r.slot_ticks            <= cfg_data[7:0];
        owtr_pkg::CFG_WRITE_LOW: cfg_r.write_low_ticks       <= cfg_data[3:0];
        owtr_pkg::CFG_READ_SAMP: cfg_r.read_sample_tick      <= cfg_data[5:0];
        owtr_pkg::CFG_CONV_WAIT: cfg_r.conv_wait_ticks       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  owtr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .start_req (in_start_req),
    .line_in   (in_line_in),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_low   = res_r.drive_low;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_no_device   = res_r.no_device;
  assign out_temperature = res_r.temperature;

endmodule
`default_nettype wire

>>> bench/one_wire_temperature_reader_checker.sv
// Checker for the one-wire temperature reader: predicts every bus tick result and compares it.
module one_wire_temperature_reader_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          in_start_req,
  input  wire logic                          in_line_in,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_drive_low,
  input  wire logic                          out_busy_res,
  input  wire logic                          out_done_res,
  input  wire logic                          out_no_device,
  input  wire logic [15:0]                   out_temperature,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [owtr_pkg::CfgDataW-1:0] cfg_data,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 reads_done,
  output int                                 absent_reads
);

  localparam logic [2:0] ByteSkipFirst  = 3'd0;
  localparam logic [2:0] ByteConvert    = 3'd1;
  localparam logic [2:0] ByteSkipSecond = 3'd2;
  localparam logic [2:0] ByteReadCmd    = 3'd3;
  localparam logic [2:0] ByteTempLow    = 3'd4;
  localparam logic [2:0] ByteTempHigh   = 3'd5;
  localparam logic [2:0] LastBit        = 3'd7;

  owtr_pkg::cfg_t             timing;
  owtr_pkg::phase_t           seq_phase;
  logic [owtr_pkg::TickW-1:0] tick_cnt;
  logic [2:0]                 bit_pos;
  logic [2:0]                 byte_pos;
  logic [7:0]                 shift_reg;
  logic [15:0]                temp_word;
  logic                       presence_missed;
  logic                       presence_seen;
  owtr_pkg::res_t             expected_q[$];
  int                         result_no;

  function automatic int unsigned at_least_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic finish_byte();
    logic [2:0] last_byte;
    logic       seq_done;
    last_byte = byte_pos;
    seq_done = 1'b0;
    byte_pos = byte_pos + 3'd1;
    tick_cnt = '0;
    bit_pos = '0;
    case (last_byte)
      ByteSkipFirst: begin
        shift_reg = owtr_pkg::CmdConvert;
        seq_phase = owtr_pkg::PH_WRITE;
      end
      ByteConvert: seq_phase = owtr_pkg::PH_CONV;
      ByteSkipSecond: begin
        shift_reg = owtr_pkg::CmdReadSp;
        seq_phase = owtr_pkg::PH_WRITE;
      end
      ByteReadCmd: begin
        shift_reg = '0;
        seq_phase = owtr_pkg::PH_READ;
      end
      ByteTempLow: begin
        temp_word = {8'h00, shift_reg};
        shift_reg = '0;
        seq_phase = owtr_pkg::PH_READ;
      end
      ByteTempHigh: begin
        temp_word = {shift_reg, temp_word[7:0]};
        seq_phase = owtr_pkg::PH_IDLE;
        seq_done = 1'b1;
      end
      default: seq_phase = owtr_pkg::PH_IDLE;
    endcase
    return seq_done;
  endfunction

  task automatic predict_tick(input logic start, input logic line, output owtr_pkg::res_t r);
    int unsigned slot_len;
    logic        slot_end;
    logic        seq_done;
    r = '0;
    seq_done = 1'b0;
    slot_len = at_least_one(timing.slot_ticks);
    if (seq_phase == owtr_pkg::PH_IDLE && start) begin
      seq_phase = owtr_pkg::PH_RST;
      tick_cnt = '0;
      bit_pos = '0;
      byte_pos = '0;
      presence_missed = 1'b0;
      presence_seen = 1'b0;
    end
    r.busy_res = (seq_phase != owtr_pkg::PH_IDLE);
    case (seq_phase)
      owtr_pkg::PH_RST: begin
        r.drive_low = 1'b1;
        if (tick_cnt + 1 >= at_least_one(timing.reset_low_ticks)) begin
          seq_phase = owtr_pkg::PH_PRES;
          tick_cnt = '0;
          presence_seen = 1'b0;
        end else begin
          tick_cnt++;
        end
      end
      owtr_pkg::PH_PRES: begin
        if (!line) presence_seen = 1'b1;
        if (tick_cnt + 1 >= at_least_one(timing.presence_window_ticks)) begin
          if (!presence_seen) presence_missed = 1'b1;
          shift_reg = owtr_pkg::CmdSkipRom;
          bit_pos = '0;
          tick_cnt = '0;
          seq_phase = owtr_pkg::PH_WRITE;
        end else begin
          tick_cnt++;
        end
      end
      owtr_pkg::PH_WRITE: begin
        slot_end = (tick_cnt + 1 >= slot_len);
        r.drive_low = (tick_cnt < timing.write_low_ticks) || (!shift_reg[0] && !slot_end);
        if (slot_end) begin
          shift_reg = shift_reg >> 1;
          if (bit_pos == LastBit) begin
            seq_done = finish_byte();
          end else begin
            bit_pos++;
            tick_cnt = '0;
          end
        end else begin
          tick_cnt++;
        end
      end
      owtr_pkg::PH_CONV: begin
        if (tick_cnt + 1 >= at_least_one(timing.conv_wait_ticks)) begin
          seq_phase = owtr_pkg::PH_RST;
          tick_cnt = '0;
        end else begin
          tick_cnt++;
        end
      end
      owtr_pkg::PH_READ: begin
        slot_end = (tick_cnt + 1 >= slot_len);
        r.drive_low = (tick_cnt < timing.write_low_ticks);
        if (tick_cnt == timing.read_sample_tick ||
            (slot_end && tick_cnt < timing.read_sample_tick)) begin
          shift_reg = {line, shift_reg[7:1]};
        end
        if (slot_end) begin
          if (bit_pos == LastBit) begin
            seq_done = finish_byte();
          end else begin
            bit_pos++;
            tick_cnt = '0;
          end
        end else begin
          tick_cnt++;
        end
      end
      default: ;
    endcase
    r.done_res = seq_done;
    r.no_device = presence_missed;
    r.temperature = seq_done ? temp_word : 16'h0000;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", result_no, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    owtr_pkg::res_t seen;
    owtr_pkg::res_t want;
    if (!rst_n) begin
      timing.reset_low_ticks = owtr_pkg::RstResetLow;
      timing.presence_window_ticks = owtr_pkg::RstPresWin;
      timing.slot_ticks = owtr_pkg::RstSlot;
      timing.write_low_ticks = owtr_pkg::RstWriteLow;
      timing.read_sample_tick = owtr_pkg::RstReadSamp;
      timing.conv_wait_ticks = owtr_pkg::RstConvWait;
      seq_phase = owtr_pkg::PH_IDLE;
      tick_cnt = '0;
      bit_pos = '0;
      byte_pos = '0;
      shift_reg = '0;
      temp_word = '0;
      presence_missed = 1'b0;
      presence_seen = 1'b0;
      expected_q.delete();
      mismatches = 0;
      reads_done = 0;
      absent_reads = 0;
      result_no = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_drive_low, out_busy_res, out_done_res, out_no_device, out_temperature};
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request waiting", seen.temperature, 16'h0000);
        end else begin
          want = expected_q.pop_front();
          if (seen.drive_low !== want.drive_low) begin
            report_mismatch("drive_low", {15'd0, seen.drive_low}, {15'd0, want.drive_low});
          end
          if (seen.busy_res !== want.busy_res) begin
            report_mismatch("busy_res", {15'd0, seen.busy_res}, {15'd0, want.busy_res});
          end
          if (seen.done_res !== want.done_res) begin
            report_mismatch("done_res", {15'd0, seen.done_res}, {15'd0, want.done_res});
          end
          if (seen.no_device !== want.no_device) begin
            report_mismatch("no_device", {15'd0, seen.no_device}, {15'd0, want.no_device});
          end
          if (seen.temperature !== want.temperature) begin
            report_mismatch("temperature", seen.temperature, want.temperature);
          end
          if (want.done_res) begin
            reads_done++;
            if (want.no_device) absent_reads++;
          end
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          owtr_pkg::CFG_RESET_LOW: timing.reset_low_ticks = cfg_data[9:0];
          owtr_pkg::CFG_PRES_WIN:  timing.presence_window_ticks = cfg_data[12:0];
          owtr_pkg::CFG_SLOT:      timing.slot_ticks = cfg_data[7:0];
          owtr_pkg::CFG_WRITE_LOW: timing.write_low_ticks = cfg_data[3:0];
          owtr_pkg::CFG_READ_SAMP: timing.read_sample_tick = cfg_data[5:0];
          owtr_pkg::CFG_CONV_WAIT: timing.conv_wait_ticks = cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_tick(in_start_req, in_line_in, want);
        expected_q.push_back(want);
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

>>> bench/one_wire_temperature_reader_tb.sv
// Testbench top for the one-wire temperature reader: clock, reset, stimulus and verdict.
module one_wire_temperature_reader_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int          PhaseCount = 14;

  typedef enum int {BUS_NOISY, BUS_EMPTY, BUS_PULLED} bus_mode_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_start_req = 1'b0;
  logic                          in_line_in = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_drive_low;
  logic                          out_busy_res;
  logic                          out_done_res;
  logic                          out_no_device;
  logic [15:0]                   out_temperature;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [owtr_pkg::CfgDataW-1:0] cfg_data = '0;

  int          mismatches;
  int          outstanding;
  int          reads_done;
  int          absent_reads;
  int          ticks_sent = 0;
  int          settings_used = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          rx_hold = 1'b0;

  one_wire_temperature_reader u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_line_in     (in_line_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_low  (out_drive_low),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_no_device  (out_no_device),
    .out_temperature(out_temperature),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  one_wire_temperature_reader_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_line_in     (in_line_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_low  (out_drive_low),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_no_device  (out_no_device),
    .out_temperature(out_temperature),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .reads_done     (reads_done),
    .absent_reads   (absent_reads)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic start, input logic line);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_line_in <= line;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic put_reg(input logic [owtr_pkg::CfgIdxW-1:0] idx,
                         input logic [owtr_pkg::CfgDataW-1:0] value, input int width);
    logic [owtr_pkg::CfgDataW-1:0] noise;
    noise = owtr_pkg::CfgDataW'($urandom() << width);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value | noise;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input owtr_pkg::cfg_t plan);
    logic [owtr_pkg::CfgIdxW-1:0] spare_idx;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    put_reg(owtr_pkg::CFG_RESET_LOW, owtr_pkg::CfgDataW'(plan.reset_low_ticks),
            $bits(plan.reset_low_ticks));
    put_reg(owtr_pkg::CFG_PRES_WIN, owtr_pkg::CfgDataW'(plan.presence_window_ticks),
            $bits(plan.presence_window_ticks));
    put_reg(owtr_pkg::CFG_SLOT, owtr_pkg::CfgDataW'(plan.slot_ticks),
            $bits(plan.slot_ticks));
    put_reg(owtr_pkg::CFG_WRITE_LOW, owtr_pkg::CfgDataW'(plan.write_low_ticks),
            $bits(plan.write_low_ticks));
    put_reg(owtr_pkg::CFG_READ_SAMP, owtr_pkg::CfgDataW'(plan.read_sample_tick),
            $bits(plan.read_sample_tick));
    put_reg(owtr_pkg::CFG_CONV_WAIT, plan.conv_wait_ticks, $bits(plan.conv_wait_ticks));
    spare_idx = owtr_pkg::CfgIdxW'(owtr_pkg::NumCfg + $urandom_range(0, 1));
    put_reg(spare_idx, owtr_pkg::CfgDataW'($urandom()), 0);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_ticks(input int count, input bus_mode_t bus, input int hold_at,
                           input int pause_at);
    int   n;
    logic start;
    logic line;
    for (n = 0; n < count; n++) begin
      if (n == hold_at) rx_hold = 1'b1;
      if (n == pause_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      start = ($urandom_range(0, 7) == 0);
      case (bus)
        BUS_EMPTY:  line = 1'b1;
        BUS_PULLED: line = ($urandom_range(0, 3) == 0);
        default:    line = 1'($urandom_range(0, 1));
      endcase
      send_tick(start, line);
    end
    in_valid <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        rx_hold = 1'b0;
      end
      wait_n = rx_idle ? $urandom_range(0, 15) : 0;
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    owtr_pkg::cfg_t plan;
    bus_mode_t      bus;
    int             p;
    int             n;
    int             span;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    in_valid <= 1'b0;
    write_settings('0);
    for (n = 0; n < 20; n++) begin
      send_tick(n == 12, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    for (p = 0; p < PhaseCount; p++) begin
      span = 85;
      if (p == 2) begin
        plan = '1;
        span = 200;
      end else if (p == 9) begin
        plan = '0;
        plan.slot_ticks = 8'd1;
        plan.write_low_ticks = 4'd1;
        plan.read_sample_tick = 6'd1;
      end else begin
        plan.reset_low_ticks = 10'($urandom_range(0, 5));
        plan.presence_window_ticks = 13'($urandom_range(0, 8));
        plan.slot_ticks = 8'($urandom_range(0, 3));
        plan.write_low_ticks = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(0, 2));
        plan.read_sample_tick = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                           : 6'($urandom_range(0, 4));
        plan.conv_wait_ticks = 20'($urandom_range(0, 8));
      end
      write_settings(plan);
      case ($urandom_range(0, 5))
        0:       bus = BUS_EMPTY;
        1:       bus = BUS_PULLED;
        default: bus = BUS_NOISY;
      endcase
      if (p == 4) bus = BUS_EMPTY;
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);
      if (p == 0) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else if (p == 5) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      run_ticks(span, bus, (p == 5) ? 30 : -1, (p == 7) ? 40 : -1);
    end

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("run covered %0d bus ticks under %0d timing settings", ticks_sent,
             settings_used);
    $display("%0d temperature reads finished, %0d of them with no presence pulse",
             reads_done, absent_reads);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
